[sv/wildcard_byte_pattern_search_macros.svh]
// Assertion macros for the wildcard byte pattern search block.
// Included by the top-level RTL file, which carries the concurrent assertions; no other dependencies.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`ifndef SYNTH
// Checks a property on every clock edge outside reset.
`define WBPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks a property on every clock edge, reset included.
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WBPS_ASSERT(lbl, clk, rst, prop, msg)
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/wbps_pkg.sv]
// Shared types and constants for the wildcard byte pattern search block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

   // Largest pattern the block holds, and the widths that follow from it.
   localparam int MAX_PATTERN = 64;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // Fixed field widths.
   localparam int BYTE_W      = 8;
   localparam int ENTRY_IDX_W = 6;
   localparam int CFG_LEN_W   = 7;
   localparam int COUNT_W     = 32;
   localparam int ADDR_W      = 32;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 32;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_START_ADDRESS = 4'd1;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_SCAN = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [ENTRY_IDX_W-1:0] entry_index;
      byte_type               entry_value;
      logic                   entry_wildcard;
      byte_type               data_byte;
      logic                   last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] match_count;
      logic               any_found;
      logic [ADDR_W-1:0]  last_match_address;
   } rsp_payload_type;

   // Per-cycle control that the front end hands to the matcher and the tally.
   typedef struct packed {
      logic load_en;
      logic scan_en;
      logic last;
   } step_type;

endpackage

`default_nettype wire

[sv/wbps_matcher.sv]
// Pattern store, byte window shift line and parallel window comparison.
// Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_matcher (
   input  logic                         clock,
   input  logic                         reset,
   input  wbps_pkg::step_type           step,
   input  wbps_pkg::req_payload_type    item,
   input  logic [wbps_pkg::LEN_W-1:0]   used_len,
   output logic                         match
);
   import wbps_pkg::*;

   byte_type               pat_ff   [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] wild_ff;
   byte_type               win_ff   [MAX_PATTERN];
   byte_type               win_in   [MAX_PATTERN];
   logic [LEN_W-1:0]       back_idx [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] entry_ok;
   logic [IDX_W-1:0]       load_idx;
   logic                   load_hit;

   // Pattern entry write decode; indexes past the store are dropped.
   assign load_idx = IDX_W'(item.entry_index);
   assign load_hit = step.load_en && (32'(item.entry_index) < 32'(MAX_PATTERN));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_ff[k] <= '0;
         end
         wild_ff <= '1;
      end else if (load_hit) begin
         pat_ff[load_idx]  <= item.entry_value;
         wild_ff[load_idx] <= item.entry_wildcard;
      end
   end

   // Window after the current byte has shifted in; entry 0 is the newest byte.
   always_comb begin
      win_in[0] = item.data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   // Only entries below the byte count are ever compared, so the window needs no reset.
   always_ff @(posedge clock) begin
      if (step.scan_en) begin
         for (int k = 0; k < MAX_PATTERN; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // Pattern entry j lines up with the byte that arrived used_len - 1 - j scans ago.
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         back_idx[j] = used_len - LEN_W'(1) - LEN_W'(j);
         if (LEN_W'(j) < used_len) begin
            entry_ok[j] = wild_ff[j] || (pat_ff[j] == win_in[back_idx[j][IDX_W-1:0]]);
         end else begin
            entry_ok[j] = 1'b1;
         end
      end
   end

   assign match = &entry_ok;

endmodule

`default_nettype wire

[sv/wbps_tally.sv]
// Per-region byte and match counters, last match address and result assembly.
// Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_tally (
   input  logic                            clock,
   input  logic                            reset,
   input  wbps_pkg::step_type              step,
   input  logic                            match,
   input  logic [wbps_pkg::LEN_W-1:0]      used_len,
   input  logic [wbps_pkg::ADDR_W-1:0]     region_start,
   output wbps_pkg::rsp_payload_type       result
);
   import wbps_pkg::*;

   logic [COUNT_W-1:0] bytes_ff;
   logic [COUNT_W-1:0] bytes_in;
   logic [COUNT_W-1:0] matches_ff;
   logic [COUNT_W-1:0] matches_in;
   logic [ADDR_W-1:0]  latest_ff;
   logic [ADDR_W-1:0]  latest_in;
   logic [COUNT_W-1:0] seen_sat;
   logic [COUNT_W-1:0] len_wide;
   logic [COUNT_W-1:0] matches_upd;
   logic [ADDR_W-1:0]  latest_upd;
   logic               hit;

   // Saturating byte count including the current byte.
   assign seen_sat = (bytes_ff == '1) ? bytes_ff : bytes_ff + COUNT_W'(1);
   assign len_wide = COUNT_W'(used_len);
   assign hit      = step.scan_en && match && (seen_sat >= len_wide);

   // Counter updates for this byte, before the end-of-region clear.
   always_comb begin
      matches_upd = matches_ff;
      latest_upd  = latest_ff;
      if (hit) begin
         latest_upd = region_start + ADDR_W'(seen_sat - len_wide);
         if (matches_ff != '1) begin
            matches_upd = matches_ff + COUNT_W'(1);
         end
      end
   end

   // Next state: hold on idle and loads, update on scans, clear after the last byte.
   always_comb begin
      bytes_in   = bytes_ff;
      matches_in = matches_ff;
      latest_in  = latest_ff;
      if (step.scan_en) begin
         if (step.last) begin
            bytes_in   = '0;
            matches_in = '0;
            latest_in  = '0;
         end else begin
            bytes_in   = seen_sat;
            matches_in = matches_upd;
            latest_in  = latest_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff   <= '0;
         matches_ff <= '0;
         latest_ff  <= '0;
      end else begin
         bytes_ff   <= bytes_in;
         matches_ff <= matches_in;
         latest_ff  <= latest_in;
      end
   end

   // Region summary, valid when the current byte ends the region.
   always_comb begin
      result.match_count        = matches_upd;
      result.any_found          = (matches_upd != '0);
      result.last_match_address = (matches_upd != '0) ? latest_upd : '0;
   end

endmodule

`default_nettype wire

[sv/wildcard_byte_pattern_search.sv]
// Wildcard byte pattern search: an accepted word is held in the input register, and its
// result word in the result register. One word is accepted every cycle, held back only when a
// word that ends a region meets a stalled result register. The window compare and counter
// update run between the two registers and load the result register. The window compare over
// all pattern entries is the longest path. Reset (synchronous) clears the pattern to all
// wildcards, the counters, both valids and the registers to pattern_length 1, region start 0.
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_byte_pattern_search_macros.svh"

module wildcard_byte_pattern_search (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  wbps_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output wbps_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import wbps_pkg::*;

   logic [CFG_LEN_W-1:0] pattern_length_ff;
   logic [CFG_LEN_W-1:0] pattern_length_in;
   logic [ADDR_W-1:0]    region_start_ff;
   logic [ADDR_W-1:0]    region_start_in;
   logic [LEN_W-1:0]     used_len;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   req_payload_type      s1_item_ff;
   logic                 s1_go;
   logic                 result_fire;
   step_type             step;
   logic                 match;
   rsp_payload_type      result;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_payload_type      rsp_payload_ff;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      pattern_length_in = pattern_length_ff;
      region_start_in   = region_start_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH:       pattern_length_in = csr_wdata[CFG_LEN_W-1:0];
            CSR_REGION_START_ADDRESS: region_start_in   = csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= CFG_LEN_W'(1);
         region_start_ff   <= '0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         region_start_ff   <= region_start_in;
      end
   end

   // Length in use: zero counts as one, oversize clamps to the store depth.
   always_comb begin
      if (pattern_length_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (32'(pattern_length_ff) > 32'(MAX_PATTERN)) begin
         used_len = LEN_W'(MAX_PATTERN);
      end else begin
         used_len = LEN_W'(pattern_length_ff);
      end
   end

   // The held word proceeds unless it ends a region while the result register is blocked.
   assign s1_go = s1_valid_ff &&
                  !((s1_item_ff.opcode == OP_SCAN) && s1_item_ff.last_byte &&
                    rsp_valid_ff && rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_go;
   assign result_fire = s1_go && (s1_item_ff.opcode == OP_SCAN) && s1_item_ff.last_byte;

   always_comb begin
      step.load_en = s1_go && (s1_item_ff.opcode == OP_LOAD);
      step.scan_en = s1_go && (s1_item_ff.opcode == OP_SCAN);
      step.last    = s1_item_ff.last_byte;
   end

   // Input register.
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_item_ff <= req_payload;
      end
   end

   wbps_matcher u_matcher (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (s1_item_ff),
      .used_len (used_len),
      .match    (match)
   );

   wbps_tally u_tally (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .match        (match),
      .used_len     (used_len),
      .region_start (region_start_ff),
      .result       (result)
   );

   // Result register.
   always_comb begin
      if (result_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_fire) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Checks on the block's own control and result assembly.
   `WBPS_ASSERT_ALWAYS(a_reset_clears_valids, clock, reset |=> (!s1_valid_ff && !rsp_valid_ff), "valids not cleared by reset")
   `WBPS_ASSERT(a_stall_cause, clock, reset, req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall), "input stalled without a blocked result")
   `WBPS_ASSERT(a_found_flag, clock, reset, rsp_valid_ff |-> (rsp_payload_ff.any_found == (rsp_payload_ff.match_count != '0)), "found flag disagrees with count")
   `WBPS_ASSERT(a_no_match_addr, clock, reset, (rsp_valid_ff && !rsp_payload_ff.any_found) |-> (rsp_payload_ff.last_match_address == '0), "address set without a match")
   `WBPS_ASSERT(a_result_drains, clock, reset, (rsp_valid_ff && !rsp_stall && !result_fire) |=> !rsp_valid_ff, "taken result word repeated")

endmodule

`default_nettype wire

[dv/wildcard_byte_pattern_search_tb.sv]
// Testbench for wildcard_byte_pattern_search: directed and random pattern loads and region scans,
// checked word by word against a behavioral predictor of the window search.
// Depends on wbps_pkg and the wildcard_byte_pattern_search RTL; needs no other files.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_tb;
   import wbps_pkg::*;

   localparam int PIPE_LATENCY   = 2;
   localparam int SETTLE_CYCLES  = PIPE_LATENCY + 2;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SEGMENTS       = 12;
   localparam int SEG_WORDS      = 155;
   localparam int HOLD_SEGMENT   = 8;
   // No register lives at this index; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 4'd15;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   wildcard_byte_pattern_search u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stimulus queue, expected results and run bookkeeping.
   req_payload_type pending_words[$];
   rsp_payload_type expected_tallies[$];
   int error_count   = 0;
   int words_queued  = 0;
   int send_idle_pct = 23;
   int recv_stall_pct = 75;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // Predictor state: pattern, byte window, per-region tallies and registers.
   byte_type               pat_value    [MAX_PATTERN];
   logic                   pat_wild     [MAX_PATTERN];
   byte_type               recent_bytes [MAX_PATTERN];
   logic [COUNT_W-1:0]     region_bytes_seen;
   logic [COUNT_W-1:0]     region_matches;
   logic [ADDR_W-1:0]      region_last_start;
   logic [CFG_LEN_W-1:0]   cfg_length;
   logic [ADDR_W-1:0]      cfg_base;

   // Stimulus-side copy of the pattern, used to plant matches into regions.
   byte_type               plant_value  [MAX_PATTERN];
   logic                   plant_wild   [MAX_PATTERN];

   // Pattern length actually compared: zero counts as one, too large is clipped.
   function automatic int unsigned effective_length(input logic [CFG_LEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > MAX_PATTERN) return MAX_PATTERN;
      return len;
   endfunction

   // Applies one accepted word to the predictor; returns 1 with the tally when the
   // word closes a region.
   function automatic bit search_step(input req_payload_type w, output rsp_payload_type tally);
      int unsigned n;
      int k;
      bit hit;
      tally = '0;
      if (w.opcode == OP_LOAD) begin
         pat_value[w.entry_index] = w.entry_value;
         pat_wild[w.entry_index]  = w.entry_wildcard;
         return 1'b0;
      end
      for (k = MAX_PATTERN - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = w.data_byte;
      if (region_bytes_seen != '1) region_bytes_seen++;
      n = effective_length(cfg_length);
      if (region_bytes_seen >= n) begin
         // Entry 0 of the pattern lines up with the oldest byte of the window.
         hit = 1'b1;
         for (k = 0; k < n; k++)
            if (!pat_wild[k] && recent_bytes[n-1-k] != pat_value[k]) hit = 1'b0;
         if (hit) begin
            region_last_start = cfg_base + (region_bytes_seen - n);
            if (region_matches != '1) region_matches++;
         end
      end
      if (!w.last_byte) return 1'b0;
      tally.match_count        = region_matches;
      tally.any_found          = (region_matches != 0);
      tally.last_match_address = (region_matches != 0) ? region_last_start : '0;
      region_bytes_seen = '0;
      region_matches    = '0;
      region_last_start = '0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Driver: predicts each accepted word, then offers the next one unless idling.
   always @(posedge clock) begin : word_driver
      rsp_payload_type tally;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (search_step(req_payload, tally)) expected_tallies.push_back(tally);
            pending_words.delete(0);
         end
         if (!(req_valid && req_stall)) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_words[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: each accepted result word is compared with the oldest expectation.
   always @(posedge clock) begin : result_monitor
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tallies.size() == 0) begin
            report_mismatch($sformatf("unexpected result count=%0d found=%0b addr=%h",
               rsp_payload.match_count, rsp_payload.any_found,
               rsp_payload.last_match_address));
         end else begin
            want = expected_tallies.pop_front();
            if (rsp_payload.match_count !== want.match_count)
               report_mismatch($sformatf("match_count %0d, expected %0d",
                  rsp_payload.match_count, want.match_count));
            if (rsp_payload.any_found !== want.any_found)
               report_mismatch($sformatf("any_found %b, expected %b",
                  rsp_payload.any_found, want.any_found));
            if (rsp_payload.last_match_address !== want.last_match_address)
               report_mismatch($sformatf("last_match_address %h, expected %h",
                  rsp_payload.last_match_address, want.last_match_address));
         end
      end
   end

   // Watchdog: ends the run when no handshake of any kind happens for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("wildcard_byte_pattern_search verification failed");
      $finish;
   end

   // Queues one word; loads also update the stimulus copy of the pattern.
   task automatic queue_word(input req_payload_type w);
      if (w.opcode == OP_LOAD) begin
         plant_value[w.entry_index] = w.entry_value;
         plant_wild[w.entry_index]  = w.entry_wildcard;
      end
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Fields that the operation ignores are filled with random bits.
   task automatic queue_load(input logic [ENTRY_IDX_W-1:0] idx, input byte_type val,
                             input logic wild);
      req_payload_type w;
      w = $urandom();
      w.opcode         = OP_LOAD;
      w.entry_index    = idx;
      w.entry_value    = val;
      w.entry_wildcard = wild;
      queue_word(w);
   endtask

   task automatic queue_scan(input byte_type data, input logic last);
      req_payload_type w;
      w = $urandom();
      w.opcode    = OP_SCAN;
      w.data_byte = data;
      w.last_byte = last;
      queue_word(w);
   endtask

   // Register write over the configuration port; the predictor follows on acceptance.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PATTERN_LENGTH) cfg_length = data[CFG_LEN_W-1:0];
      else if (idx == CSR_REGION_START_ADDRESS) cfg_base = data;
   endtask

   // Waits until every word is sent and every result has come back, then lets the
   // pipeline empty of loads that produce no result.
   task automatic drain_and_settle();
      do @(negedge clock);
      while (pending_words.size() != 0 || expected_tallies.size() != 0 || req_valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CFG_LEN_W-1:0] seg_len  [SEGMENTS];
      logic [ADDR_W-1:0]    seg_base [SEGMENTS];
      byte_type             region_buf [256];
      int unsigned          eff;
      int                   seg, k, j, start, choice, len_r, at, swap_at, plants;
      bit                   narrow;
      req_payload_type      w;

      for (k = 0; k < MAX_PATTERN; k++) begin
         pat_value[k]    = '0;
         pat_wild[k]     = 1'b1;
         recent_bytes[k] = '0;
         plant_value[k]  = '0;
         plant_wild[k]   = 1'b1;
      end
      region_bytes_seen = '0;
      region_matches    = '0;
      region_last_start = '0;
      cfg_length        = 1;
      cfg_base          = '0;

      // Register settings per segment, extremes and out-of-range lengths included.
      seg_len  = '{1, 64, 0, 5, 127, 3, 1, 8, 2, 65, 4, 1};
      seg_len[6]  = $urandom_range(1, 64);
      seg_len[9]  = $urandom_range(65, 127);
      seg_len[11] = $urandom_range(1, 16);
      seg_base = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFF0, 32'h0, 32'h0,
                   32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FF00, 32'h0};
      seg_base[2]  = $urandom();
      seg_base[4]  = $urandom();
      seg_base[6]  = $urandom();
      seg_base[7]  = $urandom();
      seg_base[8]  = $urandom();
      seg_base[11] = $urandom();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings: length one, all-wildcard pattern, then entries 0, 63 and 62 loaded.
      @(negedge clock);
      queue_scan(8'h00, 1'b1);
      queue_scan(8'hFF, 1'b0);
      queue_scan(8'h80, 1'b1);
      queue_load(6'd0, 8'hA5, 1'b0);
      queue_load(6'd63, 8'hFF, 1'b0);
      queue_load(6'd62, 8'h00, 1'b1);
      queue_scan(8'hA5, 1'b0);
      queue_scan(8'h5A, 1'b0);
      queue_scan(8'hA5, 1'b1);
      queue_scan(8'h00, 1'b1);

      // Directed, length three near the top of the address space: short region,
      // overlapping matches with address wrap, pattern rewritten mid-region.
      drain_and_settle();
      csr_write(CSR_PATTERN_LENGTH, 32'd3);
      csr_write(CSR_REGION_START_ADDRESS, 32'hFFFF_FFFE);
      @(negedge clock);
      queue_load(6'd0, 8'h11, 1'b0);
      queue_load(6'd1, 8'hFF, 1'b1);
      queue_load(6'd2, 8'h11, 1'b0);
      queue_scan(8'h11, 1'b1);
      queue_scan(8'h11, 1'b0);
      queue_scan(8'h22, 1'b0);
      queue_scan(8'h11, 1'b0);
      queue_scan(8'h44, 1'b0);
      queue_scan(8'h11, 1'b1);
      queue_scan(8'h11, 1'b0);
      queue_scan(8'h00, 1'b0);
      queue_load(6'd2, 8'h33, 1'b0);
      queue_scan(8'h33, 1'b1);

      // Random segments, each with its own register setting and idling mode.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         drain_and_settle();
         csr_write(CSR_PATTERN_LENGTH,
                   ($urandom_range(1) ? ($urandom() & ~32'h7F) : 32'h0) | seg_len[seg]);
         csr_write(CSR_REGION_START_ADDRESS, seg_base[seg]);
         if (seg == 6) csr_write(CSR_SPARE_INDEX, $urandom());
         @(negedge clock);
         if (seg < 4) begin
            send_idle_pct  = 23;
            recv_stall_pct = 75;
         end else if (seg < 8) begin
            send_idle_pct  = 75;
            recv_stall_pct = 23;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         if (seg == HOLD_SEGMENT) hold_requests++;

         eff   = effective_length(seg_len[seg]);
         start = words_queued;
         for (k = 0; k < eff; k++) queue_load(k, $urandom(), $urandom_range(9) < 3);
         repeat ($urandom_range(3)) queue_load($urandom_range(63), $urandom(), $urandom_range(1));

         while (words_queued - start < SEG_WORDS) begin
            choice = $urandom_range(9);
            if (choice == 0) begin
               // Noise: a fully random word.
               w = $urandom();
               queue_word(w);
            end else if (choice == 1 && eff > 1) begin
               // Region shorter than the pattern.
               len_r = $urandom_range(1, eff - 1);
               for (k = 0; k < len_r; k++) queue_scan($urandom(), k == len_r - 1);
            end else begin
               // Region with the pattern planted one or more times, overlaps allowed.
               len_r  = $urandom_range(eff, 2 * eff + 6);
               narrow = $urandom_range(1);
               for (k = 0; k < len_r; k++)
                  region_buf[k] = narrow ? ($urandom_range(1) ? 8'h00 : 8'hFF) : $urandom();
               plants = $urandom_range(1, 3);
               repeat (plants) begin
                  at = $urandom_range(0, len_r - eff);
                  for (j = 0; j < eff; j++)
                     if (!plant_wild[j]) region_buf[at + j] = plant_value[j];
               end
               swap_at = ($urandom_range(5) == 0) ? $urandom_range(len_r - 1) : -1;
               for (k = 0; k < len_r; k++) begin
                  if (k == swap_at)
                     queue_load($urandom_range(eff - 1), $urandom(), $urandom_range(1));
                  queue_scan(region_buf[k], k == len_r - 1);
               end
            end
         end
         queue_scan($urandom(), 1'b1);
      end

      drain_and_settle();
      if (error_count == 0)
         $display("wildcard_byte_pattern_search verification clean");
      else
         $display("wildcard_byte_pattern_search verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/wbps_pkg.sv
sv/wbps_matcher.sv
sv/wbps_tally.sv
sv/wildcard_byte_pattern_search.sv
dv/wildcard_byte_pattern_search_tb.sv
